@@ design/fbpa_pkg.sv @@
package fbpa_pkg;

	localparam int NUM_BLOCKS_DEF = 16;
	localparam int BSIZE_W        = 13;
	localparam int OFFSET_W       = 16;
	localparam int STATUS_W       = 3;
	localparam int FCOUNT_W       = 5;
	localparam logic [BSIZE_W-1:0] BSIZE_RST = 13'd64;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_FULL,
		ST_MISALIGNED,
		ST_RANGE,
		ST_NOT_ALLOC
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_WB,
		S_DIV,
		S_REL_RD,
		S_REL_WB,
		S_DONE
	} state_t;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

endpackage

@@ design/fbpa_ram.sv @@
module fbpa_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/fixed_block_pool_allocator.sv @@
// Allocate: read link, write back, load output; a full pool skips the write back.
// Release: the bit-serial offset / block_size divider, then read link, write back, load output;
//   a misaligned or out-of-range offset skips the write back.
// One item at a time: next input accepted once the previous result sits in the output register.
// Reset (arst_n low) empties the output, sets block_size to 64 and the free list to 0..N-1;
//   the link RAM is not cleared, a fill mark treats never-written entries as holding index+1.
module fixed_block_pool_allocator #(
	parameter int NumBlocks = fbpa_pkg::NUM_BLOCKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,

	// configuration write channel: block size in bytes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fbpa_pkg::BSIZE_W-1:0]     block_size,

	// request channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             func,
	input  logic [fbpa_pkg::OFFSET_W-1:0]    release_offset,

	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [fbpa_pkg::STATUS_W-1:0]    status,
	output logic [fbpa_pkg::OFFSET_W-1:0]    block_offset,
	output logic [fbpa_pkg::FCOUNT_W-1:0]    free_count
);

	import fbpa_pkg::*;

	// Index into the link RAM; link entries also code END (= NumBlocks)
	// and ALLOC (= NumBlocks + 1).
	localparam int IDX_W  = $clog2(NumBlocks);
	localparam int LINK_W = $clog2(NumBlocks + 2);
	localparam int PROD_W = IDX_W + BSIZE_W;
	localparam int DIV_STEPS = OFFSET_W;
	localparam int CNT_W  = $clog2(DIV_STEPS);

	localparam logic [LINK_W-1:0] END_MARK   = LINK_W'(NumBlocks);
	localparam logic [LINK_W-1:0] ALLOC_MARK = LINK_W'(NumBlocks + 1);
	localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(DIV_STEPS - 1);

	state_t state_q, state_d;

	// control state
	logic [BSIZE_W-1:0] block_size_q;
	logic [LINK_W-1:0]  head_q;       // free list head, END_MARK when empty
	logic [LINK_W-1:0]  free_q;       // free block count
	logic [LINK_W-1:0]  fill_q;       // entries at or above this were never written
	logic               out_valid_q;
	logic [CNT_W-1:0]   cnt_q;

	// working registers
	logic [BSIZE_W-1:0]  bs_q;        // block size for this item, zero read as one
	logic [OFFSET_W-1:0] quot_q;      // offset in, quotient out
	logic [BSIZE_W-1:0]  rem_q;
	logic [PROD_W-1:0]   prod_q;      // head * block size
	status_t             res_status_q;
	logic [OFFSET_W-1:0] res_off_q;
	status_t             status_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [FCOUNT_W-1:0] fcount_q;

	// RAM port
	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [LINK_W-1:0] ram_wdata, ram_rdata;

	// decode helpers
	logic                out_free;
	logic                head_end;
	logic                misaligned;
	logic                out_of_range;
	logic [IDX_W-1:0]    head_idx;
	logic [IDX_W-1:0]    rel_idx;
	logic [LINK_W-1:0]   rel_link;
	logic [LINK_W-1:0]   next_head;
	logic                rel_alloc;
	logic [BSIZE_W:0]    div_shift;
	logic                div_ge;
	logic [BSIZE_W-1:0]  div_rem;
	logic [31:0]         prod_ext;
	logic [31:0]         free_ext;

	assign out_free     = !out_valid_q || out_ready;
	assign head_end     = (head_q >= END_MARK);
	assign misaligned   = (rem_q != '0);
	assign out_of_range = (quot_q >= OFFSET_W'(NumBlocks));
	assign head_idx     = head_q[IDX_W-1:0];
	assign rel_idx      = quot_q[IDX_W-1:0];
	assign rel_link     = LINK_W'(rel_idx);

	// Untouched entries read as their reset link, index + 1 (END for the last).
	assign next_head = (head_q >= fill_q) ? head_q + 1'b1 : ram_rdata;
	// A never-written entry cannot be allocated.
	assign rel_alloc = (rel_link < fill_q) && (ram_rdata == ALLOC_MARK);

	// restoring divider step: one quotient bit per cycle
	assign div_shift = {rem_q, quot_q[OFFSET_W-1]};
	assign div_ge    = (div_shift >= {1'b0, bs_q});
	assign div_rem   = div_ge ? BSIZE_W'(div_shift - {1'b0, bs_q}) : div_shift[BSIZE_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (func == FUNC_RELEASE) ? S_DIV : S_ALLOC_RD;
				end
			end
			S_ALLOC_RD: state_d = head_end ? S_DONE : S_ALLOC_WB;
			S_ALLOC_WB: state_d = S_DONE;
			S_DIV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = S_REL_RD;
				end
			end
			S_REL_RD: state_d = (misaligned || out_of_range) ? S_DONE : S_REL_WB;
			S_REL_WB: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = head_idx;
		ram_we    = 1'b0;
		ram_waddr = head_idx;
		ram_wdata = ALLOC_MARK;
		case (state_q)
			S_IDLE:     in_ready = 1'b1;
			S_ALLOC_RD: ram_re = !head_end;
			S_ALLOC_WB: ram_we = 1'b1;
			S_REL_RD: begin
				ram_re    = !(misaligned || out_of_range);
				ram_raddr = rel_idx;
			end
			S_REL_WB: begin
				ram_we    = rel_alloc;
				ram_waddr = rel_idx;
				ram_wdata = head_q;
			end
			default: ;
		endcase
	end

	fbpa_ram #(
		.Width (LINK_W),
		.Depth (NumBlocks)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			block_size_q <= BSIZE_RST;
			head_q       <= '0;
			free_q       <= LINK_W'(NumBlocks);
			fill_q       <= '0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				block_size_q <= block_size;
			end
			case (state_q)
				S_IDLE: cnt_q <= '0;
				S_DIV:  cnt_q <= cnt_q + 1'b1;
				S_ALLOC_WB: begin
					head_q <= next_head;
					free_q <= free_q - 1'b1;
					if (head_q == fill_q) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				S_REL_WB: begin
					if (rel_alloc) begin
						head_q <= rel_link;
						free_q <= free_q + 1'b1;
					end
				end
				default: ;
			endcase
			// a new result may load in the same cycle the old one transfers out
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				bs_q         <= (block_size_q == '0) ? BSIZE_W'(1) : block_size_q;
				quot_q       <= release_offset;
				rem_q        <= '0;
				res_status_q <= ST_OK;
				res_off_q    <= '0;
			end
			S_ALLOC_RD: begin
				prod_q <= PROD_W'(head_idx) * PROD_W'(bs_q);
				if (head_end) begin
					res_status_q <= ST_FULL;
				end
			end
			S_ALLOC_WB: res_off_q <= prod_ext[OFFSET_W-1:0];
			S_DIV: begin
				rem_q  <= div_rem;
				quot_q <= {quot_q[OFFSET_W-2:0], div_ge};
			end
			S_REL_RD: begin
				if (misaligned) begin
					res_status_q <= ST_MISALIGNED;
				end else if (out_of_range) begin
					res_status_q <= ST_RANGE;
				end
			end
			S_REL_WB: begin
				if (!rel_alloc) begin
					res_status_q <= ST_NOT_ALLOC;
				end
			end
			S_DONE: begin
				if (out_free) begin
					status_q <= res_status_q;
					offset_q <= res_off_q;
					fcount_q <= free_ext[FCOUNT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign prod_ext = 32'(prod_q);
	assign free_ext = 32'(free_q);

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign status       = STATUS_W'(status_q);
	assign block_offset = offset_q;
	// free count captured with the result; the next item may change free_q while it waits
	assign free_count   = fcount_q;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import fbpa_pkg::*;

	// Pool geometry as built into the block under test.
	localparam int NBLK = NUM_BLOCKS_DEF;
	localparam int LINK_W = $clog2(NBLK + 2);
	// Link table marks: one past the last index ends the list, two past marks a block in use.
	localparam logic [LINK_W-1:0] LINK_END   = LINK_W'(NBLK);
	localparam logic [LINK_W-1:0] LINK_ALLOC = LINK_W'(NBLK + 1);
	// Watchdog limit on the run, counted in clock cycles.
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		status_t               st;
		logic [OFFSET_W-1:0]   offs;
		logic [FCOUNT_W-1:0]   fcnt;
	} pool_reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [BSIZE_W-1:0]    block_size;
	logic                  in_valid;
	logic                  in_ready;
	logic                  func;
	logic [OFFSET_W-1:0]   release_offset;
	logic                  out_valid;
	logic                  out_ready;
	logic [STATUS_W-1:0]   status;
	logic [OFFSET_W-1:0]   block_offset;
	logic [FCOUNT_W-1:0]   free_count;

	fixed_block_pool_allocator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.block_size     (block_size),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.release_offset (release_offset),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.block_offset   (block_offset),
		.free_count     (free_count)
	);

	// Shadow copy of the allocator: free list, head, count and the block size in force.
	logic [LINK_W-1:0]     link_tab [NBLK];
	logic [LINK_W-1:0]     free_head;
	logic [FCOUNT_W-1:0]   free_cnt;
	logic [BSIZE_W-1:0]    pool_bsize;

	// Replies predicted at input transfer, oldest first.
	pool_reply_t replies_due [$];
	int mismatches = 0;
	int cycle_cnt = 0;

	// Receiver control: the main thread bumps hold_reqs, the receiver process does the counting.
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;
	bit rx_quiet = 0;
	bit tx_quiet = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(25, 80);
	endfunction

	function automatic int eff_bsize();
		// a zero block size decodes as one byte
		return (pool_bsize == '0) ? 1 : int'(pool_bsize);
	endfunction

	function automatic void reset_pool_model();
		for (int i = 0; i < NBLK; i++)
			link_tab[i] = LINK_W'(i + 1);
		link_tab[NBLK-1] = LINK_END;
		free_head = '0;
		free_cnt = FCOUNT_W'(NBLK);
		pool_bsize = BSIZE_RST;
	endfunction

	// Applies one request to the shadow pool and returns the reply it must produce.
	function automatic pool_reply_t pool_apply(input logic op, input logic [OFFSET_W-1:0] off);
		pool_reply_t r;
		int bs;
		int idx;
		bs = eff_bsize();
		r.st = ST_OK;
		r.offs = '0;
		if (op == FUNC_ALLOC) begin
			if (free_head >= LINK_END) begin
				r.st = ST_FULL;
			end else begin
				idx = int'(free_head);
				free_head = link_tab[idx];
				link_tab[idx] = LINK_ALLOC;
				free_cnt = free_cnt - 1'b1;
				// offset wraps at 16 bits for large block sizes
				r.offs = OFFSET_W'(idx * bs);
			end
		end else begin
			// check order: alignment, then range, then whether the block is in use
			if (int'(off) % bs != 0) begin
				r.st = ST_MISALIGNED;
			end else begin
				idx = int'(off) / bs;
				if (idx >= NBLK) begin
					r.st = ST_RANGE;
				end else if (link_tab[idx] != LINK_ALLOC) begin
					r.st = ST_NOT_ALLOC;
				end else begin
					link_tab[idx] = free_head;
					free_head = LINK_W'(idx);
					free_cnt = free_cnt + 1'b1;
				end
			end
		end
		r.fcnt = free_cnt;
		return r;
	endfunction

	// One request transfer. Inputs move at the falling edge; the transfer is seen at the rising edge.
	task automatic send_req(input logic op, input logic [OFFSET_W-1:0] off);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_quiet = !tx_quiet;
		gap = tx_quiet ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		func = op;
		release_offset = off;
		do @(posedge clk); while (!in_ready);
		replies_due.push_back(pool_apply(op, off));
	endtask

	// Sender stops and waits until every predicted reply has come back.
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		wait (replies_due.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	// Block size write; only called with the pool idle.
	task automatic set_block_size(input logic [BSIZE_W-1:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		block_size = v;
		do @(posedge clk); while (!cfg_ready);
		pool_bsize = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly well-formed traffic: allocates and releases of blocks in use.
	// The rest is noise: random offsets, out-of-range multiples, double releases, off-by-a-few.
	task automatic random_item();
		int r;
		int pick;
		int bs;
		int held [$];
		int loose [$];
		bs = eff_bsize();
		for (int i = 0; i < NBLK; i++) begin
			if (link_tab[i] == LINK_ALLOC)
				held.push_back(i);
			else
				loose.push_back(i);
		end
		r = $urandom_range(0, 99);
		if (r < 45 || (r < 85 && held.size() == 0)) begin
			send_req(FUNC_ALLOC, OFFSET_W'($urandom));
		end else if (r < 85) begin
			pick = held[$urandom_range(0, held.size() - 1)];
			send_req(FUNC_RELEASE, OFFSET_W'(pick * bs));
		end else begin
			case ($urandom_range(0, 3))
				0: send_req(FUNC_RELEASE, OFFSET_W'($urandom));
				1: send_req(FUNC_RELEASE, OFFSET_W'(bs * $urandom_range(NBLK, NBLK + 30)));
				2: begin
					if (loose.size() > 0) begin
						pick = loose[$urandom_range(0, loose.size() - 1)];
						send_req(FUNC_RELEASE, OFFSET_W'(pick * bs));
					end else begin
						send_req(FUNC_RELEASE, OFFSET_W'($urandom));
					end
				end
				default: send_req(FUNC_RELEASE,
					OFFSET_W'(bs * $urandom_range(0, NBLK - 1) + $urandom_range(1, 3)));
			endcase
		end
	endtask

	// Reset block size: drain the pool, overflow it, then hit each release error.
	task automatic test_directed_reset();
		repeat (NBLK) send_req(FUNC_ALLOC, OFFSET_W'($urandom));
		send_req(FUNC_ALLOC, '1);                          // pool full
		send_req(FUNC_RELEASE, OFFSET_W'(1));              // misaligned
		send_req(FUNC_RELEASE, '1);                        // all-ones offset, misaligned
		send_req(FUNC_RELEASE, OFFSET_W'(NBLK * 64));      // first index past the pool
		send_req(FUNC_RELEASE, OFFSET_W'(1023 * 64));      // largest aligned offset
		send_req(FUNC_RELEASE, '0);                        // good release of block 0
		send_req(FUNC_RELEASE, '0);                        // double release
		send_req(FUNC_RELEASE, OFFSET_W'((NBLK - 1) * 64)); // last block
	endtask

	task automatic test_random_phase(input logic [BSIZE_W-1:0] bs, input int n);
		wait_drained();
		set_block_size(bs);
		repeat (n) random_item();
	endtask

	// Receiver holds off for a long stretch while requests keep coming, so the input stalls.
	task automatic test_output_backpressure();
		hold_reqs++;
		repeat (15) random_item();
	endtask

	task automatic test_pause_until_drained();
		repeat (20) random_item();
		wait_drained();
		repeat (20) random_item();
	endtask

	// Receiver: random stalls, quiet stretches, and the long hold on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = 400;
			end
			if ($urandom_range(0, 199) == 0)
				rx_quiet = !rx_quiet;
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				if (!rx_quiet && $urandom_range(0, 4) == 0)
					stall_left = idle_len() + 1;
			end
		end
	end

	// Reply checker: every output transfer against the oldest prediction.
	always @(posedge clk) begin
		pool_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				$error("unexpected reply: status %0d block_offset %0d free_count %0d",
					status, block_offset, free_count);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					mismatches++;
				end
				if (block_offset !== want.offs) begin
					$error("block_offset: expected %0d, got %0d", want.offs, block_offset);
					mismatches++;
				end
				if (free_count !== want.fcnt) begin
					$error("free_count: expected %0d, got %0d", want.fcnt, free_count);
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		block_size = BSIZE_RST;
		in_valid = 1'b0;
		func = FUNC_ALLOC;
		release_offset = '0;
		reset_pool_model();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_reset();
		test_random_phase(BSIZE_RST, 90);
		test_random_phase(BSIZE_W'(1), 90);
		test_output_backpressure();
		test_random_phase(BSIZE_W'(4096), 80);
		test_random_phase('1, 80);              // largest register value, offsets wrap
		test_random_phase('0, 70);              // zero decodes as one byte
		test_pause_until_drained();
		test_random_phase(BSIZE_W'($urandom_range(2, 200)), 160);

		// allow time for stray replies after the drain
		wait_drained();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
